// ===== design/lnsc_pkg.sv =====
// ============================================================================
// lnsc_pkg: shared types and constants of the noise sound channel
// Operation codes, register addresses, reset values and the period and
// length lookup tables.
// ============================================================================
`default_nettype none

package lnsc_pkg;

    typedef enum logic [2:0] {
        OP_REG_WRITE  = 3'd0,
        OP_CTRL_WRITE = 3'd1,
        OP_TICK       = 3'd2,
        OP_LEN_CLK    = 3'd3,
        OP_ENV_CLK    = 3'd4,
        OP_STATUS     = 3'd5
    } t_op;

    localparam logic [1:0] REG_ENVELOPE = 2'd0;
    localparam logic [1:0] REG_SPARE    = 2'd1;
    localparam logic [1:0] REG_PERIOD   = 2'd2;
    localparam logic [1:0] REG_LENGTH   = 2'd3;

    localparam logic       KIND_LEVEL  = 1'b0;
    localparam logic       KIND_STATUS = 1'b1;

    localparam logic [14:0] LFSR_RESET    = 15'h0001;
    localparam logic [11:0] PERIOD_RESET  = 12'h004;
    localparam logic [7:0]  LENGTH_RESET  = 8'd11;
    localparam logic [4:0]  ENV_PER_RESET = 5'd1;
    localparam logic [3:0]  ENV_LVL_MAX   = 4'hF;
    localparam logic [5:0]  ENV_DIV_MAX   = 6'd16;
    localparam logic [11:0] TIMER_MAX     = 12'hFE4;

    // Timer control from the register decoder to the timer/shift register unit.
    typedef struct packed {
        logic       tick;
        logic       period_we;
        logic [3:0] period_sel;
        logic       short_mode;
    } t_tmr_ctl;

    function automatic logic [11:0] period_lookup(input logic [3:0] sel);
        logic [11:0] p;
        case (sel)
            4'd0:    p = 12'h004;
            4'd1:    p = 12'h008;
            4'd2:    p = 12'h010;
            4'd3:    p = 12'h020;
            4'd4:    p = 12'h040;
            4'd5:    p = 12'h060;
            4'd6:    p = 12'h080;
            4'd7:    p = 12'h0A0;
            4'd8:    p = 12'h0CA;
            4'd9:    p = 12'h0FE;
            4'd10:   p = 12'h17C;
            4'd11:   p = 12'h1FC;
            4'd12:   p = 12'h2FA;
            4'd13:   p = 12'h3F8;
            4'd14:   p = 12'h7F2;
            default: p = 12'hFE4;
        endcase
        return p;
    endfunction

    function automatic logic [7:0] length_lookup(input logic [4:0] sel);
        logic [7:0] n;
        case (sel)
            5'd0:    n = 8'd10;
            5'd1:    n = 8'd254;
            5'd2:    n = 8'd20;
            5'd3:    n = 8'd2;
            5'd4:    n = 8'd40;
            5'd5:    n = 8'd4;
            5'd6:    n = 8'd80;
            5'd7:    n = 8'd6;
            5'd8:    n = 8'd160;
            5'd9:    n = 8'd8;
            5'd10:   n = 8'd60;
            5'd11:   n = 8'd10;
            5'd12:   n = 8'd14;
            5'd13:   n = 8'd12;
            5'd14:   n = 8'd26;
            5'd15:   n = 8'd14;
            5'd16:   n = 8'd12;
            5'd17:   n = 8'd16;
            5'd18:   n = 8'd24;
            5'd19:   n = 8'd18;
            5'd20:   n = 8'd48;
            5'd21:   n = 8'd20;
            5'd22:   n = 8'd96;
            5'd23:   n = 8'd22;
            5'd24:   n = 8'd192;
            5'd25:   n = 8'd24;
            5'd26:   n = 8'd72;
            5'd27:   n = 8'd26;
            5'd28:   n = 8'd16;
            5'd29:   n = 8'd28;
            5'd30:   n = 8'd32;
            default: n = 8'd30;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

// ===== design/lfsr_noise_sound_channel_unit.sv =====
// ============================================================================
// lfsr_noise_sound_channel_unit: noise sound channel
// Register decode, length counter, envelope and result register around the
// period timer and noise shift register.
// ============================================================================
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one operation per transfer:
//   a channel register write, a control write, a clock tick, a length clock,
//   an envelope clock or a status read. Output channel (o_out_valid /
//   i_out_ready) carries the results: a level change caused by a tick, or the
//   answer to a status read. Other operations give no result.
//   Each operation is worked out in the cycle of its transfer and its result,
//   if any, appears in the output register in the next cycle. One operation is
//   taken every cycle while the input is ready; the throughput is then one item per clock.
//   The input stays ready while the output register is empty or is being
//   drained in the same cycle, so a stalled receiver stops new transfers only
//   once a result is waiting in the output register.
//   Synchronous reset (i_rst_n low) returns the channel to its power-on
//   registers: shift register 1, shortest period, length count 11, envelope
//   level 15, channel disabled, output register empty.
// ============================================================================
`default_nettype none

module lfsr_noise_sound_channel_unit (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  wire  [2:0]  i_op,
    input  wire  [1:0]  i_reg_addr,
    input  wire  [7:0]  i_reg_value,
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output logic        o_kind,
    output logic [3:0]  o_level,
    output logic        o_active
);

    logic               accept;
    lnsc_pkg::t_op      op;
    lnsc_pkg::t_tmr_ctl tmr_ctl;
    logic               tmr_bit;

    logic        r_loop,     n_loop;
    logic        r_cvol,     n_cvol;
    logic [3:0]  r_fixed,    n_fixed;
    logic [4:0]  r_env_per,  n_env_per;
    logic signed [5:0] r_env_div, n_env_div;
    logic [3:0]  r_env_lvl,  n_env_lvl;
    logic [7:0]  r_length,   n_length;
    logic        r_chan_on,  n_chan_on;
    logic        r_ctl_en,   n_ctl_en;
    logic        r_last_bit, n_last_bit;

    logic        r_out_valid;
    logic        r_kind;
    logic [3:0]  r_level;
    logic        r_active;

    logic        res_valid;
    logic        res_kind;
    logic [3:0]  res_level;
    logic        res_active;
    logic        audible;
    logic signed [5:0] div_dec;

    assign o_in_ready = ~r_out_valid | i_out_ready;
    assign accept     = i_in_valid & o_in_ready;
    assign op         = lnsc_pkg::t_op'(i_op);
    assign audible    = r_chan_on & (r_length != 8'd0);
    assign div_dec    = r_env_div - 6'sd1;

    always_comb begin
        n_loop     = r_loop;
        n_cvol     = r_cvol;
        n_fixed    = r_fixed;
        n_env_per  = r_env_per;
        n_env_div  = r_env_div;
        n_env_lvl  = r_env_lvl;
        n_length   = r_length;
        n_chan_on  = r_chan_on;
        n_ctl_en   = r_ctl_en;
        n_last_bit = r_last_bit;
        tmr_ctl    = '0;
        tmr_ctl.period_sel = i_reg_value[3:0];
        tmr_ctl.short_mode = i_reg_value[7];
        res_valid  = 1'b0;
        res_kind   = lnsc_pkg::KIND_LEVEL;
        res_level  = 4'd0;
        res_active = 1'b0;
        if (accept) begin
            unique case (op)
                lnsc_pkg::OP_REG_WRITE: begin
                    unique case (i_reg_addr)
                        lnsc_pkg::REG_ENVELOPE: begin
                            n_loop    = i_reg_value[5];
                            n_cvol    = i_reg_value[4];
                            n_fixed   = i_reg_value[3:0];
                            n_env_per = {1'b0, i_reg_value[3:0]} + 5'd1;
                        end
                        lnsc_pkg::REG_PERIOD: begin
                            tmr_ctl.period_we = 1'b1;
                        end
                        lnsc_pkg::REG_LENGTH: begin
                            n_length  = lnsc_pkg::length_lookup(i_reg_value[7:3]) + 8'd1;
                            n_env_lvl = lnsc_pkg::ENV_LVL_MAX;
                            if (r_ctl_en) begin
                                n_chan_on = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                lnsc_pkg::OP_CTRL_WRITE: begin
                    n_ctl_en = i_reg_value[0];
                    if (!i_reg_value[0]) begin
                        n_chan_on = 1'b0;
                    end
                end
                lnsc_pkg::OP_TICK: begin
                    tmr_ctl.tick = 1'b1;
                    if (audible && (r_last_bit != tmr_bit)) begin
                        n_last_bit = tmr_bit;
                        res_valid  = 1'b1;
                        res_level  = tmr_bit ? (r_cvol ? r_fixed : r_env_lvl) : 4'd0;
                    end
                end
                lnsc_pkg::OP_LEN_CLK: begin
                    if (!r_loop && (r_length != 8'd0)) begin
                        n_length = r_length - 8'd1;
                    end
                end
                lnsc_pkg::OP_ENV_CLK: begin
                    n_env_div = div_dec;
                    if (div_dec < 6'sd1) begin
                        n_env_div = div_dec + $signed({1'b0, r_env_per});
                        if (!r_cvol) begin
                            if (r_loop) begin
                                n_env_lvl = r_env_lvl - 4'd1;
                            end else if (r_env_lvl != 4'd0) begin
                                n_env_lvl = r_env_lvl - 4'd1;
                            end
                        end
                    end
                end
                lnsc_pkg::OP_STATUS: begin
                    res_valid  = 1'b1;
                    res_kind   = lnsc_pkg::KIND_STATUS;
                    res_active = audible;
                end
                default: begin
                end
            endcase
        end
    end

    lnsc_lfsr_timer u_lfsr_timer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (tmr_ctl),
        .o_bit   (tmr_bit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loop     <= 1'b0;
            r_cvol     <= 1'b0;
            r_fixed    <= 4'd0;
            r_env_per  <= lnsc_pkg::ENV_PER_RESET;
            r_env_div  <= 6'sd0;
            r_env_lvl  <= lnsc_pkg::ENV_LVL_MAX;
            r_length   <= lnsc_pkg::LENGTH_RESET;
            r_chan_on  <= 1'b0;
            r_ctl_en   <= 1'b0;
            r_last_bit <= 1'b0;
        end else begin
            r_loop     <= n_loop;
            r_cvol     <= n_cvol;
            r_fixed    <= n_fixed;
            r_env_per  <= n_env_per;
            r_env_div  <= n_env_div;
            r_env_lvl  <= n_env_lvl;
            r_length   <= n_length;
            r_chan_on  <= n_chan_on;
            r_ctl_en   <= n_ctl_en;
            r_last_bit <= n_last_bit;
        end
    end

    // The output register is reloaded whenever it is empty or being drained.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && res_valid) begin
            r_kind   <= res_kind;
            r_level  <= res_level;
            r_active <= res_active;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_kind;
    assign o_level     = r_level;
    assign o_active    = r_active;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (op == lnsc_pkg::OP_STATUS)) |=> (o_out_valid && o_kind))
        else $error("status read gave no answer");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_kind == lnsc_pkg::KIND_LEVEL)) |-> !o_active)
        else $error("level result carries an active flag");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_kind == lnsc_pkg::KIND_STATUS)) |-> (o_level == 4'd0))
        else $error("status answer carries a level");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_env_div >= 6'sd0) && (r_env_div <= $signed(lnsc_pkg::ENV_DIV_MAX)))
        else $error("envelope divider out of range");

endmodule

`default_nettype wire

// ===== design/lnsc_lfsr_timer.sv =====
// ============================================================================
// lnsc_lfsr_timer: period timer and 15-bit noise shift register
// Counts down on each tick; on expiry it reloads and shifts the register
// once, feeding back bit 0 XOR bit 1 (long mode) or bit 6 (short mode).
// ============================================================================
`default_nettype none

module lnsc_lfsr_timer (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire lnsc_pkg::t_tmr_ctl  i_ctl,
    output logic                     o_bit
);

    logic [14:0] r_lfsr,   n_lfsr;
    logic [11:0] r_count,  n_count;
    logic [11:0] r_period, n_period;
    logic        r_short,  n_short;
    logic        expire;
    logic        fb;

    assign expire = (r_count <= 12'd1);
    assign fb     = r_lfsr[0] ^ (r_short ? r_lfsr[6] : r_lfsr[1]);

    // Bit 0 as it stands after this tick: on expiry the old bit 1 moves down.
    assign o_bit  = expire ? r_lfsr[1] : r_lfsr[0];

    always_comb begin
        n_lfsr   = r_lfsr;
        n_count  = r_count;
        n_period = r_period;
        n_short  = r_short;
        if (i_ctl.tick) begin
            if (expire) begin
                n_count = r_period - 12'd1 + r_count;
                n_lfsr  = {fb, r_lfsr[14:1]};
            end else begin
                n_count = r_count - 12'd1;
            end
        end
        if (i_ctl.period_we) begin
            n_period = lnsc_pkg::period_lookup(i_ctl.period_sel);
            n_short  = i_ctl.short_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lfsr   <= lnsc_pkg::LFSR_RESET;
            r_count  <= 12'd0;
            r_period <= lnsc_pkg::PERIOD_RESET;
            r_short  <= 1'b0;
        end else begin
            r_lfsr   <= n_lfsr;
            r_count  <= n_count;
            r_period <= n_period;
            r_short  <= n_short;
        end
    end

    // A shift register with a zero seed would lock up for good.
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_lfsr != 15'd0)
        else $error("noise shift register reached zero");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= lnsc_pkg::TIMER_MAX)
        else $error("timer count beyond the longest period");

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb: self-checking testbench for the noise sound channel
// A queue of operations feeds a clocked driver on the input channel. A
// clocked monitor mirrors the channel state on every input transfer and
// checks each output transfer against the oldest predicted result. Both
// sides idle at random, and the run ends with a pass or fail verdict.
// ============================================================================
`default_nettype none

module tb;

    localparam int ITEMS      = 2000;
    localparam int IDLE_LIMIT = 1000;
    localparam int TAIL       = 8;

    localparam logic [11:0] PERIODS [16] = '{
        12'h004, 12'h008, 12'h010, 12'h020, 12'h040, 12'h060, 12'h080, 12'h0A0,
        12'h0CA, 12'h0FE, 12'h17C, 12'h1FC, 12'h2FA, 12'h3F8, 12'h7F2, 12'hFE4
    };
    localparam logic [7:0] LENGTHS [32] = '{
        8'd10,  8'd254, 8'd20, 8'd2,  8'd40, 8'd4,  8'd80, 8'd6,
        8'd160, 8'd8,   8'd60, 8'd10, 8'd14, 8'd12, 8'd26, 8'd14,
        8'd12,  8'd16,  8'd24, 8'd18, 8'd48, 8'd20, 8'd96, 8'd22,
        8'd192, 8'd24,  8'd72, 8'd26, 8'd16, 8'd28, 8'd32, 8'd30
    };

    typedef struct {
        logic [2:0] op;
        logic [1:0] addr;
        logic [7:0] val;
        bit         drain;
    } t_stim;

    typedef struct packed {
        logic       kind;
        logic [3:0] level;
        logic       active;
    } t_result;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [2:0] i_op;
    logic [1:0] i_reg_addr;
    logic [7:0] i_reg_value;
    logic       o_out_valid;
    logic       i_out_ready;
    logic       o_kind;
    logic [3:0] o_level;
    logic       o_active;

    lfsr_noise_sound_channel_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_op        (i_op),
        .i_reg_addr  (i_reg_addr),
        .i_reg_value (i_reg_value),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_kind      (o_kind),
        .o_level     (o_level),
        .o_active    (o_active)
    );

    t_stim   op_fifo[$];
    t_result due_outputs[$];

    // Mirrored channel state.
    logic [14:0] nz_lfsr;
    logic [11:0] tmr_cnt;
    logic [11:0] tmr_per;
    logic        short_md;
    logic        loop_hlt;
    logic        const_vol;
    logic [3:0]  fix_lvl;
    logic [4:0]  env_per;
    int          env_div;
    logic [3:0]  env_lvl;
    logic [7:0]  len_cnt;
    logic        chan_on;
    logic        ctl_en;
    logic        last_bit;

    int    fail_count   = 0;
    int    idle_cycles  = 0;
    int    send_wait    = 0;
    int    send_calm    = 0;
    int    recv_wait    = 0;
    int    recv_calm    = 0;
    bit    in_took      = 1'b0;
    bit    out_took     = 1'b0;
    t_stim cur;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic flag_mismatch(input string msg);
        fail_count++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    function automatic t_stim stim(input logic [2:0] op, input logic [1:0] a,
                                   input logic [7:0] v);
        t_stim s;
        s.op    = op;
        s.addr  = a;
        s.val   = v;
        s.drain = 1'b0;
        return s;
    endfunction

    // Mostly uniform waits, with the odd stretch of back-to-back transfers.
    function automatic int draw_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0) begin
            calm = int'($urandom_range(20, 60));
            return 0;
        end
        return int'($urandom_range(0, 17));
    endfunction

    task automatic noise_channel_reset();
        nz_lfsr   = lnsc_pkg::LFSR_RESET;
        tmr_cnt   = 12'd0;
        tmr_per   = PERIODS[0];
        short_md  = 1'b0;
        loop_hlt  = 1'b0;
        const_vol = 1'b0;
        fix_lvl   = 4'd0;
        env_per   = 5'd1;
        env_div   = 0;
        env_lvl   = 4'hF;
        len_cnt   = LENGTHS[0] + 8'd1;
        chan_on   = 1'b0;
        ctl_en    = 1'b0;
        last_bit  = 1'b0;
    endtask

    task automatic noise_channel_step(input logic [2:0] op, input logic [1:0] addr,
                                      input logic [7:0] val);
        logic    audible;
        logic    fb;
        t_result r;
        case (op)
            lnsc_pkg::OP_REG_WRITE: begin
                case (addr)
                    lnsc_pkg::REG_ENVELOPE: begin
                        loop_hlt  = val[5];
                        const_vol = val[4];
                        fix_lvl   = val[3:0];
                        env_per   = {1'b0, val[3:0]} + 5'd1;
                    end
                    lnsc_pkg::REG_PERIOD: begin
                        tmr_per  = PERIODS[val[3:0]];
                        short_md = val[7];
                    end
                    lnsc_pkg::REG_LENGTH: begin
                        len_cnt = LENGTHS[val[7:3]] + 8'd1;
                        env_lvl = 4'hF;
                        if (ctl_en) chan_on = 1'b1;
                    end
                    default: ;
                endcase
            end
            lnsc_pkg::OP_CTRL_WRITE: begin
                ctl_en = val[0];
                if (!ctl_en) chan_on = 1'b0;
            end
            lnsc_pkg::OP_TICK: begin
                audible = chan_on && (len_cnt != 8'd0);
                if (tmr_cnt <= 12'd1) begin
                    fb      = nz_lfsr[0] ^ (short_md ? nz_lfsr[6] : nz_lfsr[1]);
                    tmr_cnt = tmr_per - 12'd1 + tmr_cnt;
                    nz_lfsr = {fb, nz_lfsr[14:1]};
                end else begin
                    tmr_cnt = tmr_cnt - 12'd1;
                end
                // A silent channel keeps its last bit, so it may speak at once later.
                if (audible && last_bit != nz_lfsr[0]) begin
                    last_bit = nz_lfsr[0];
                    r.kind   = lnsc_pkg::KIND_LEVEL;
                    r.level  = last_bit ? (const_vol ? fix_lvl : env_lvl) : 4'd0;
                    r.active = 1'b0;
                    due_outputs.push_back(r);
                end
            end
            lnsc_pkg::OP_LEN_CLK: begin
                if (!loop_hlt && len_cnt != 8'd0) len_cnt = len_cnt - 8'd1;
            end
            lnsc_pkg::OP_ENV_CLK: begin
                env_div--;
                if (env_div < 1) begin
                    env_div += int'(env_per);
                    if (!const_vol) begin
                        if (loop_hlt) env_lvl = env_lvl - 4'd1;
                        else if (env_lvl != 4'd0) env_lvl = env_lvl - 4'd1;
                    end
                end
            end
            lnsc_pkg::OP_STATUS: begin
                r.kind   = lnsc_pkg::KIND_STATUS;
                r.level  = 4'd0;
                r.active = (len_cnt != 8'd0) && chan_on;
                due_outputs.push_back(r);
            end
            default: ;
        endcase
    endtask

    // One burst of stimulus: usually a full channel set-up followed by a run
    // of mostly ticks, sometimes a handful of arbitrary operations.
    task automatic push_phrase(inout int counted);
        logic [7:0] v;
        logic [3:0] sel;
        int         n;
        int         r;
        if ($urandom_range(0, 9) < 7) begin
            v    = 8'($urandom);
            v[0] = ($urandom_range(0, 7) != 0);
            op_fifo.push_back(stim(lnsc_pkg::OP_CTRL_WRITE, 2'($urandom), v));
            op_fifo.push_back(stim(lnsc_pkg::OP_REG_WRITE, lnsc_pkg::REG_ENVELOPE,
                                   8'($urandom)));
            sel = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(0, 15))
                                               : 4'($urandom_range(0, 3));
            v   = 8'($urandom);
            op_fifo.push_back(stim(lnsc_pkg::OP_REG_WRITE, lnsc_pkg::REG_PERIOD,
                                   {v[7:4], sel}));
            op_fifo.push_back(stim(lnsc_pkg::OP_REG_WRITE, lnsc_pkg::REG_LENGTH,
                                   8'($urandom)));
            counted += 4;
            n = int'($urandom_range(20, 80));
            repeat (n) begin
                r = int'($urandom_range(0, 99));
                if (r < 80)
                    op_fifo.push_back(stim(lnsc_pkg::OP_TICK, 2'($urandom), 8'($urandom)));
                else if (r < 87)
                    op_fifo.push_back(stim(lnsc_pkg::OP_ENV_CLK, 2'($urandom), 8'($urandom)));
                else if (r < 91)
                    op_fifo.push_back(stim(lnsc_pkg::OP_LEN_CLK, 2'($urandom), 8'($urandom)));
                else if (r < 96)
                    op_fifo.push_back(stim(lnsc_pkg::OP_STATUS, 2'($urandom), 8'($urandom)));
                else
                    op_fifo.push_back(stim(lnsc_pkg::OP_REG_WRITE, 2'($urandom),
                                           8'($urandom)));
                counted++;
            end
        end else begin
            n = int'($urandom_range(3, 12));
            repeat (n) begin
                op_fifo.push_back(stim(3'($urandom_range(0, 7)), 2'($urandom),
                                       8'($urandom)));
                if (op_fifo[$].op <= lnsc_pkg::OP_STATUS) counted++;
            end
        end
    endtask

    // Driver: a new item goes out at the falling edge once the previous one
    // has been transferred and its wait has run out.
    always @(negedge i_clk) begin
        logic nv;
        nv = i_in_valid;
        if (i_rst_n) begin
            if (i_in_valid && in_took) nv = 1'b0;
            if (!nv) begin
                if (send_wait > 0) begin
                    send_wait--;
                end else if (op_fifo.size() > 0) begin
                    if (op_fifo[0].drain) begin
                        if (due_outputs.size() == 0) void'(op_fifo.pop_front());
                    end else begin
                        cur = op_fifo.pop_front();
                        i_op        <= cur.op;
                        i_reg_addr  <= cur.addr;
                        i_reg_value <= cur.val;
                        nv = 1'b1;
                        send_wait = draw_wait(send_calm);
                    end
                end
            end
        end
        i_in_valid <= nv;
    end

    // Receiver: after each result transfer, hold ready low for a drawn stall.
    always @(negedge i_clk) begin
        if (out_took) recv_wait = draw_wait(recv_calm);
        if (recv_wait > 0) begin
            recv_wait--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Monitor: results are checked before the input transfer of the same edge
    // is mirrored, since a result always belongs to an earlier transfer.
    always @(posedge i_clk) begin
        t_result want;
        in_took  = 1'b0;
        out_took = 1'b0;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                out_took = 1'b1;
                if (due_outputs.size() == 0) begin
                    flag_mismatch($sformatf("result with none due: kind %0b level %0d active %0b",
                                            o_kind, o_level, o_active));
                end else begin
                    want = due_outputs.pop_front();
                    if (o_kind !== want.kind)
                        flag_mismatch($sformatf("kind %0b, wanted %0b", o_kind, want.kind));
                    if (o_level !== want.level)
                        flag_mismatch($sformatf("level %0d, wanted %0d", o_level, want.level));
                    if (o_active !== want.active)
                        flag_mismatch($sformatf("active %0b, wanted %0b", o_active, want.active));
                end
            end
            if (i_in_valid && o_in_ready) begin
                in_took = 1'b1;
                noise_channel_step(i_op, i_reg_addr, i_reg_value);
            end
            if (in_took || out_took) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT) begin
                    $display("CHECKS FAILED");
                    $finish;
                end
            end
        end
    end

    initial begin
        int    counted;
        bit    drained;
        t_stim hold;
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_op        = lnsc_pkg::OP_REG_WRITE;
        i_reg_addr  = lnsc_pkg::REG_ENVELOPE;
        i_reg_value = 8'd0;
        i_out_ready = 1'b0;
        noise_channel_reset();

        // Directed: reset status, a silent tick, every register at its
        // extremes, envelope decay, halted length, disable and unknown ops.
        op_fifo.push_back(stim(lnsc_pkg::OP_STATUS, 2'd3, 8'hFF));
        op_fifo.push_back(stim(lnsc_pkg::OP_TICK, 2'd0, 8'h00));
        op_fifo.push_back(stim(lnsc_pkg::OP_CTRL_WRITE, 2'd0, 8'hFF));
        op_fifo.push_back(stim(lnsc_pkg::OP_REG_WRITE, lnsc_pkg::REG_ENVELOPE, 8'h3F));
        op_fifo.push_back(stim(lnsc_pkg::OP_REG_WRITE, lnsc_pkg::REG_PERIOD, 8'h80));
        op_fifo.push_back(stim(lnsc_pkg::OP_REG_WRITE, lnsc_pkg::REG_LENGTH, 8'hFF));
        op_fifo.push_back(stim(lnsc_pkg::OP_STATUS, 2'd0, 8'h00));
        repeat (4) op_fifo.push_back(stim(lnsc_pkg::OP_TICK, 2'd3, 8'hFF));
        op_fifo.push_back(stim(lnsc_pkg::OP_REG_WRITE, lnsc_pkg::REG_SPARE, 8'hAA));
        op_fifo.push_back(stim(lnsc_pkg::OP_ENV_CLK, 2'd0, 8'h00));
        op_fifo.push_back(stim(lnsc_pkg::OP_REG_WRITE, lnsc_pkg::REG_ENVELOPE, 8'h00));
        op_fifo.push_back(stim(lnsc_pkg::OP_ENV_CLK, 2'd1, 8'h55));
        op_fifo.push_back(stim(lnsc_pkg::OP_ENV_CLK, 2'd2, 8'hAA));
        op_fifo.push_back(stim(lnsc_pkg::OP_LEN_CLK, 2'd0, 8'h00));
        op_fifo.push_back(stim(lnsc_pkg::OP_REG_WRITE, lnsc_pkg::REG_ENVELOPE, 8'hE0));
        op_fifo.push_back(stim(lnsc_pkg::OP_LEN_CLK, 2'd3, 8'hFF));
        op_fifo.push_back(stim(lnsc_pkg::OP_REG_WRITE, lnsc_pkg::REG_PERIOD, 8'h7F));
        op_fifo.push_back(stim(lnsc_pkg::OP_REG_WRITE, lnsc_pkg::REG_LENGTH, 8'h08));
        op_fifo.push_back(stim(lnsc_pkg::OP_CTRL_WRITE, 2'd3, 8'hFE));
        op_fifo.push_back(stim(lnsc_pkg::OP_STATUS, 2'd1, 8'h00));
        op_fifo.push_back(stim(3'd6, 2'd2, 8'h5A));
        op_fifo.push_back(stim(3'd7, 2'd1, 8'hA5));

        counted = 0;
        drained = 1'b0;
        while (counted < ITEMS) begin
            push_phrase(counted);
            // Halfway through, the sender holds off until all results are in.
            if (!drained && counted >= ITEMS / 2) begin
                hold       = stim(lnsc_pkg::OP_STATUS, 2'd0, 8'h00);
                hold.drain = 1'b1;
                op_fifo.push_back(hold);
                drained = 1'b1;
            end
        end

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (op_fifo.size() != 0 || i_in_valid || due_outputs.size() != 0)
            @(negedge i_clk);
        repeat (TAIL) @(posedge i_clk);
        if (due_outputs.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", due_outputs.size()));

        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
